// ===== sv/bpe_pkg.sv =====
package bpe_pkg;

  // Default sizes, handed to the top level parameters
  localparam int SEQ_MAX_DEF  = 128;
  localparam int SLOT_MAX_DEF = 16;

  // Id space is fixed by the 7-bit id field
  localparam int ID_W     = 7;
  localparam int ID_COUNT = 1 << ID_W;

  // Result and register widths
  localparam int CNT_W   = 8;
  localparam int SLOTS_W = 5;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // Register index, taken from the word address bit of the config port
  localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_BACK_A,
    ST_BACK_B,
    ST_BACK_C,
    ST_REP_RD,
    ST_REP_ISSUE,
    ST_REP_WAIT,
    ST_OUT
  } state_t;

  // Flags carried by the lookup token along the slot chain
  typedef struct packed {
    logic vld;
    logic hit;
    logic free;
  } tok_flags_t;

endpackage

// ===== sv/bpe_ram.sv =====
module bpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bpe_cell.sv =====
module bpe_cell #(
  parameter int SEQ_MAX  = bpe_pkg::SEQ_MAX_DEF,
  parameter int SLOT_MAX = bpe_pkg::SLOT_MAX_DEF,
  parameter int IDX      = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        clear,
  input  logic [$clog2(SLOT_MAX+1)-1:0]               cap,
  // token in from the previous cell
  input  bpe_pkg::tok_flags_t                         flg_in,
  input  logic [bpe_pkg::ID_W-1:0]                    id_in,
  input  logic [$clog2(SEQ_MAX+1)-1:0]                nxt_in,
  input  logic [$clog2(SEQ_MAX+1)-1:0]                best_val_in,
  input  logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] best_idx_in,
  input  logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] hit_idx_in,
  input  logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] free_idx_in,
  // token out to the next cell
  output bpe_pkg::tok_flags_t                         flg_out,
  output logic [bpe_pkg::ID_W-1:0]                    id_out,
  output logic [$clog2(SEQ_MAX+1)-1:0]                nxt_out,
  output logic [$clog2(SEQ_MAX+1)-1:0]                best_val_out,
  output logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] best_idx_out,
  output logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] hit_idx_out,
  output logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] free_idx_out,
  // slot update broadcast
  input  logic                                        wr_en,
  input  logic [((SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1)-1:0] wr_idx,
  input  logic [bpe_pkg::ID_W-1:0]                    wr_id,
  input  logic [$clog2(SEQ_MAX+1)-1:0]                wr_nxt
);

  localparam int PW = $clog2(SEQ_MAX+1);
  localparam int SW = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;

  logic                 valid_r, valid_nxt;
  logic [bpe_pkg::ID_W-1:0] id_r, id_nxt;
  logic [PW-1:0]        nu_r, nu_nxt;

  bpe_pkg::tok_flags_t  flg_r, flg_nxt;
  logic [bpe_pkg::ID_W-1:0] tid_r;
  logic [PW-1:0]        tnxt_r;
  logic [PW-1:0]        bval_r, bval_nxt;
  logic [SW-1:0]        bidx_r, bidx_nxt;
  logic [SW-1:0]        hidx_r, hidx_nxt;
  logic [SW-1:0]        fidx_r, fidx_nxt;
  logic                 en;

  // Fold this slot into the token: hit, first free slot, farthest next use
  always_comb begin
    en       = (32'(cap) > IDX);
    flg_nxt  = flg_in;
    bval_nxt = best_val_in;
    bidx_nxt = best_idx_in;
    hidx_nxt = hit_idx_in;
    fidx_nxt = free_idx_in;
    if (en && valid_r && (id_r == id_in)) begin
      flg_nxt.hit = 1'b1;
      hidx_nxt    = SW'(IDX);
    end
    if (en && !valid_r && !flg_in.free) begin
      flg_nxt.free = 1'b1;
      fidx_nxt     = SW'(IDX);
    end
    if (en && ((IDX == 0) || (nu_r > best_val_in))) begin
      bval_nxt = nu_r;
      bidx_nxt = SW'(IDX);
    end
  end

  // Clear the slot, or update it on a broadcast aimed at this cell
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    nu_nxt    = nu_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (wr_en && (wr_idx == SW'(IDX))) begin
      valid_nxt = 1'b1;
      id_nxt    = wr_id;
      nu_nxt    = wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flg_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      flg_r   <= flg_nxt;
    end
  end

  // Slot payload and token payload need no reset
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    nu_r       <= nu_nxt;
    tid_r      <= id_in;
    tnxt_r     <= nxt_in;
    bval_r     <= bval_nxt;
    bidx_r     <= bidx_nxt;
    hidx_r     <= hidx_nxt;
    fidx_r     <= fidx_nxt;
  end

  assign flg_out      = flg_r;
  assign id_out       = tid_r;
  assign nxt_out      = tnxt_r;
  assign best_val_out = bval_r;
  assign best_idx_out = bidx_r;
  assign hit_idx_out  = hidx_r;
  assign free_idx_out = fidx_r;

endmodule

// ===== sv/belady_optimal_eviction_counter.sv =====
// Load: one input word per cycle; in_stall is low only while loading.
// After the last word: a clear of all 128 entries of the last-use table (ID_COUNT),
// a backward next-use pass through states BACK_A, BACK_B and BACK_C per position,
// a replay with the lookup token walking the slot chain, and the result state.
// The result state waits while the previous result word is still stalled.
// Synchronous active-low reset clears control state and sets slots_in_use to 1.
module belady_optimal_eviction_counter #(
  parameter int SEQ_MAX  = bpe_pkg::SEQ_MAX_DEF,
  parameter int SLOT_MAX = bpe_pkg::SLOT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpe_pkg::ID_W-1:0]      in_item_id,
  input  logic                          in_is_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpe_pkg::CNT_W-1:0]     out_eviction_count,
  output logic                          out_overflow,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bpe_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [bpe_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [bpe_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int PW  = $clog2(SEQ_MAX+1);
  localparam int AW  = $clog2(SEQ_MAX);
  localparam int SW  = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
  localparam int CW  = $clog2(SLOT_MAX+1);
  localparam int IW  = bpe_pkg::ID_W;
  localparam int NW  = bpe_pkg::CNT_W;
  localparam int DW  = bpe_pkg::CFG_DW;
  localparam int LW  = bpe_pkg::SLOTS_W;
  localparam logic [PW-1:0] NEVER = PW'(SEQ_MAX);

  bpe_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]  slots_r, slots_nxt;
  logic [PW-1:0]  len_r, len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  cap_r, cap_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic [NW-1:0]  evict_r, evict_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [NW-1:0]  out_cnt_r, out_cnt_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           in_acc, cfg_wr, out_free, store_ok;
  logic [PW-1:0]  pos_m1;

  // memory ports
  logic           seq_we;
  logic [AW-1:0]  seq_raddr;
  logic [IW-1:0]  seq_rdata;
  logic           nu_we;
  logic [PW-1:0]  nu_rdata;
  logic           ls_we;
  logic [IW-1:0]  ls_waddr;
  logic [PW-1:0]  ls_wdata;
  logic [PW-1:0]  ls_rdata;

  // slot chain
  bpe_pkg::tok_flags_t chain_flg  [SLOT_MAX+1];
  logic [IW-1:0]       chain_id   [SLOT_MAX+1];
  logic [PW-1:0]       chain_nxt  [SLOT_MAX+1];
  logic [PW-1:0]       chain_bval [SLOT_MAX+1];
  logic [SW-1:0]       chain_bidx [SLOT_MAX+1];
  logic [SW-1:0]       chain_hidx [SLOT_MAX+1];
  logic [SW-1:0]       chain_fidx [SLOT_MAX+1];
  logic                cell_clear;
  logic                launch;
  logic                wr_en;
  logic [SW-1:0]       wr_idx;
  logic                evict;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free = !out_valid_r || !out_stall;
  assign store_ok = (len_r != NEVER);
  assign pos_m1   = pos_r - PW'(1);

  // Configuration register
  always_comb begin
    slots_nxt = slots_r;
    if (cfg_wr && (cfg_paddr[2] == bpe_pkg::REG_SLOTS_IN_USE)) begin
      slots_nxt = cfg_pwdata[LW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == bpe_pkg::REG_SLOTS_IN_USE) ?
                      DW'(slots_r) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpe_pkg::ST_LOAD: begin
        if (in_acc && in_is_last) state_nxt = bpe_pkg::ST_CLEAR;
      end
      bpe_pkg::ST_CLEAR: begin
        if (clr_r == IW'(bpe_pkg::ID_COUNT - 1)) state_nxt = bpe_pkg::ST_BACK_A;
      end
      bpe_pkg::ST_BACK_A: begin
        state_nxt = (pos_r == '0) ? bpe_pkg::ST_REP_RD : bpe_pkg::ST_BACK_B;
      end
      bpe_pkg::ST_BACK_B: state_nxt = bpe_pkg::ST_BACK_C;
      bpe_pkg::ST_BACK_C: state_nxt = bpe_pkg::ST_BACK_A;
      bpe_pkg::ST_REP_RD: begin
        state_nxt = (pos_r == len_r) ? bpe_pkg::ST_OUT : bpe_pkg::ST_REP_ISSUE;
      end
      bpe_pkg::ST_REP_ISSUE: state_nxt = bpe_pkg::ST_REP_WAIT;
      bpe_pkg::ST_REP_WAIT: begin
        if (chain_flg[SLOT_MAX].vld) state_nxt = bpe_pkg::ST_REP_RD;
      end
      bpe_pkg::ST_OUT: begin
        if (out_free) state_nxt = bpe_pkg::ST_LOAD;
      end
      default: state_nxt = bpe_pkg::ST_LOAD;
    endcase
  end

  // State outputs: handshake, memory strobes, chain control
  always_comb begin
    in_stall   = 1'b1;
    seq_we     = 1'b0;
    nu_we      = 1'b0;
    ls_we      = 1'b0;
    ls_waddr   = seq_rdata;
    ls_wdata   = pos_m1;
    seq_raddr  = pos_r[AW-1:0];
    cell_clear = 1'b0;
    launch     = 1'b0;
    wr_en      = 1'b0;
    case (state_r)
      bpe_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        seq_we   = in_acc && store_ok;
      end
      bpe_pkg::ST_CLEAR: begin
        ls_we      = 1'b1;
        ls_waddr   = clr_r;
        ls_wdata   = NEVER;
        cell_clear = 1'b1;
      end
      bpe_pkg::ST_BACK_A, bpe_pkg::ST_BACK_B: begin
        seq_raddr = pos_m1[AW-1:0];
      end
      bpe_pkg::ST_BACK_C: begin
        seq_raddr = pos_m1[AW-1:0];
        nu_we     = 1'b1;
        ls_we     = 1'b1;
      end
      bpe_pkg::ST_REP_ISSUE: begin
        launch = 1'b1;
      end
      bpe_pkg::ST_REP_WAIT: begin
        wr_en = chain_flg[SLOT_MAX].vld;
      end
      default: begin
      end
    endcase
  end

  // Pick the slot to write: the hit, else the first free, else the farthest
  always_comb begin
    evict = !chain_flg[SLOT_MAX].hit && !chain_flg[SLOT_MAX].free;
    if (chain_flg[SLOT_MAX].hit) begin
      wr_idx = chain_hidx[SLOT_MAX];
    end else if (chain_flg[SLOT_MAX].free) begin
      wr_idx = chain_fidx[SLOT_MAX];
    end else begin
      wr_idx = chain_bidx[SLOT_MAX];
    end
  end

  // Datapath registers
  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    cap_nxt       = cap_r;
    pos_nxt       = pos_r;
    clr_nxt       = clr_r;
    evict_nxt     = evict_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      bpe_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) len_nxt = len_r + PW'(1);
          else          ovf_nxt = 1'b1;
          if (in_is_last) begin
            clr_nxt = '0;
            if (slots_r == '0) begin
              cap_nxt = CW'(1);
            end else if (32'(slots_r) > SLOT_MAX) begin
              cap_nxt = CW'(SLOT_MAX);
            end else begin
              cap_nxt = CW'(slots_r);
            end
          end
        end
      end
      bpe_pkg::ST_CLEAR: begin
        clr_nxt   = clr_r + IW'(1);
        pos_nxt   = len_r;
        evict_nxt = '0;
      end
      bpe_pkg::ST_BACK_C: begin
        pos_nxt = pos_m1;
      end
      bpe_pkg::ST_REP_WAIT: begin
        if (chain_flg[SLOT_MAX].vld) begin
          pos_nxt = pos_r + PW'(1);
          if (evict && (evict_r != bpe_pkg::CNT_SAT)) evict_nxt = evict_r + NW'(1);
        end
      end
      bpe_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = evict_r;
          out_ovf_nxt   = ovf_r;
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpe_pkg::ST_LOAD;
      slots_r     <= LW'(1);
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slots_r     <= slots_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r     <= cap_nxt;
    pos_r     <= pos_nxt;
    clr_r     <= clr_nxt;
    evict_r   <= evict_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_eviction_count = out_cnt_r;
  assign out_overflow       = out_ovf_r;

  // Stored sequence of ids
  bpe_ram #(.WIDTH(IW), .DEPTH(SEQ_MAX)) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_item_id),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  // Next use of each position
  bpe_ram #(.WIDTH(PW), .DEPTH(SEQ_MAX)) u_nu_ram (
    .clk   (clk),
    .we    (nu_we),
    .waddr (pos_m1[AW-1:0]),
    .wdata (ls_rdata),
    .raddr (pos_r[AW-1:0]),
    .rdata (nu_rdata)
  );

  // Latest position seen for each id during the backward pass
  bpe_ram #(.WIDTH(PW), .DEPTH(bpe_pkg::ID_COUNT)) u_ls_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (seq_rdata),
    .rdata (ls_rdata)
  );

  // Launch a fresh token into the head of the chain
  always_comb begin
    chain_flg[0].vld  = launch;
    chain_flg[0].hit  = 1'b0;
    chain_flg[0].free = 1'b0;
    chain_id[0]       = seq_rdata;
    chain_nxt[0]      = nu_rdata;
    chain_bval[0]     = '0;
    chain_bidx[0]     = '0;
    chain_hidx[0]     = '0;
    chain_fidx[0]     = '0;
  end

  for (genvar g = 0; g < SLOT_MAX; g++) begin : g_cell
    bpe_cell #(.SEQ_MAX(SEQ_MAX), .SLOT_MAX(SLOT_MAX), .IDX(g)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .clear        (cell_clear),
      .cap          (cap_r),
      .flg_in       (chain_flg[g]),
      .id_in        (chain_id[g]),
      .nxt_in       (chain_nxt[g]),
      .best_val_in  (chain_bval[g]),
      .best_idx_in  (chain_bidx[g]),
      .hit_idx_in   (chain_hidx[g]),
      .free_idx_in  (chain_fidx[g]),
      .flg_out      (chain_flg[g+1]),
      .id_out       (chain_id[g+1]),
      .nxt_out      (chain_nxt[g+1]),
      .best_val_out (chain_bval[g+1]),
      .best_idx_out (chain_bidx[g+1]),
      .hit_idx_out  (chain_hidx[g+1]),
      .free_idx_out (chain_fidx[g+1]),
      .wr_en        (wr_en),
      .wr_idx       (wr_idx),
      .wr_id        (chain_id[SLOT_MAX]),
      .wr_nxt       (chain_nxt[SLOT_MAX])
    );
  end

  // A new result word appears only from the result state
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == bpe_pkg::ST_OUT)
    else $error("result word raised outside the result state");

  // A token leaves the chain only while the replay waits for it
  a_token_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    chain_flg[SLOT_MAX].vld |-> state_r == bpe_pkg::ST_REP_WAIT)
    else $error("lookup token left the chain outside replay");

  // Dropped words only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == NEVER)
    else $error("overflow flagged with room left in the store");

  // Nothing is taken in while the replay runs
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bpe_pkg::ST_LOAD) |=> $stable(len_r) || (len_r == '0))
    else $error("sequence length moved during computation");

endmodule

// ===== test/belady_eviction_checker.sv =====
module belady_eviction_checker
  import bpe_pkg::*;
#(
  parameter int SEQ_MAX  = SEQ_MAX_DEF,
  parameter int SLOT_MAX = SLOT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [ID_W-1:0]   in_item_id,
  input  logic              in_is_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CNT_W-1:0]  out_eviction_count,
  input  logic              out_overflow,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                results_pending,
  output int                results_checked
);

  typedef struct packed {
    logic [CNT_W-1:0] evictions;
    logic             overflow;
  } tally_t;

  // Tallies owed by the block, oldest first
  tally_t             tally_q[$];
  // Sequence as loaded so far
  logic [ID_W-1:0]    loaded_ids[SEQ_MAX];
  int                 loaded_len = 0;
  logic               overflow_seen = 1'b0;
  logic [SLOTS_W-1:0] slots_cfg = SLOTS_W'(1);
  int                 errs = 0;
  int                 checked = 0;

  // Replay the loaded sequence under farthest-next-use replacement
  function automatic logic [CNT_W-1:0] optimal_evictions(input int len,
                                                         input logic [SLOTS_W-1:0] slots);
    int              next_pos[SEQ_MAX];
    int              last_pos[ID_COUNT];
    logic [ID_W-1:0] slot_id[SLOT_MAX];
    logic            slot_full[SLOT_MAX];
    int              slot_next[SLOT_MAX];
    int              cap;
    int              count;
    int              victim;
    int              free_idx;
    logic            hit;
    cap = (slots == 0) ? 1 : (int'(slots) > SLOT_MAX) ? SLOT_MAX : int'(slots);
    // backward pass: next position of the same id, or never
    foreach (last_pos[k]) last_pos[k] = SEQ_MAX;
    for (int i = len - 1; i >= 0; i--) begin
      next_pos[i] = last_pos[loaded_ids[i]];
      last_pos[loaded_ids[i]] = i;
    end
    foreach (slot_full[j]) begin
      slot_full[j] = 1'b0;
      slot_id[j]   = '0;
      slot_next[j] = 0;
    end
    count = 0;
    for (int i = 0; i < len; i++) begin
      hit      = 1'b0;
      free_idx = -1;
      for (int j = 0; j < cap; j++) begin
        if (slot_full[j] && slot_id[j] == loaded_ids[i]) begin
          hit = 1'b1;
          slot_next[j] = next_pos[i];
        end
        if (!slot_full[j] && free_idx < 0) free_idx = j;
      end
      if (hit) continue;
      // fill the lowest free slot without counting
      if (free_idx >= 0) begin
        slot_full[free_idx] = 1'b1;
        slot_id[free_idx]   = loaded_ids[i];
        slot_next[free_idx] = next_pos[i];
        continue;
      end
      // evict the farthest next use, lowest slot on a tie
      victim = 0;
      for (int j = 1; j < cap; j++) begin
        if (slot_next[j] > slot_next[victim]) victim = j;
      end
      slot_id[victim]   = loaded_ids[i];
      slot_next[victim] = next_pos[i];
      if (count < 255) count++;
    end
    return CNT_W'(count);
  endfunction

  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      loaded_len    = 0;
      overflow_seen = 1'b0;
      slots_cfg     = SLOTS_W'(1);
      tally_q.delete();
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_SLOTS_IN_USE) begin
        slots_cfg = cfg_pwdata[SLOTS_W-1:0];
      end
      // compare each result word with the oldest tally
      if (out_valid && !out_stall) begin
        if (tally_q.size() == 0) begin
          $display("%0t: unexpected result word, eviction_count %0d overflow %0b",
                   $time, out_eviction_count, out_overflow);
          errs++;
        end else begin
          want = tally_q[0];
          tally_q.delete(0);
          checked++;
          if (out_eviction_count !== want.evictions) begin
            $display("%0t: eviction_count expected %0d got %0d",
                     $time, want.evictions, out_eviction_count);
            errs++;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b got %0b",
                     $time, want.overflow, out_overflow);
            errs++;
          end
        end
      end
      // store accepted input words; drop past capacity
      if (in_valid && !in_stall) begin
        if (loaded_len < SEQ_MAX) begin
          loaded_ids[loaded_len] = in_item_id;
          loaded_len++;
        end else begin
          overflow_seen = 1'b1;
        end
        if (in_is_last) begin
          want.evictions = optimal_evictions(loaded_len, slots_cfg);
          want.overflow  = overflow_seen;
          tally_q        = {tally_q, want};
          loaded_len     = 0;
          overflow_seen  = 1'b0;
        end
      end
    end
    fail_count      <= errs;
    results_pending <= tally_q.size();
    results_checked <= checked;
  end

endmodule

// ===== test/tb_belady_optimal_eviction_counter.sv =====
module tb_belady_optimal_eviction_counter;
  import bpe_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ID_W-1:0]     in_item_id = '0;
  logic                in_is_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CNT_W-1:0]    out_eviction_count;
  logic                out_overflow;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int fail_count;
  int results_pending;
  int results_checked;

  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int words_sent = 0;
  int seqs_sent = 0;
  int overflow_seqs = 0;
  int settings_used = 0;

  belady_optimal_eviction_counter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item_id         (in_item_id),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_eviction_count (out_eviction_count),
    .out_overflow       (out_overflow),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  belady_eviction_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item_id         (in_item_id),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_eviction_count (out_eviction_count),
    .out_overflow       (out_overflow),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_pready         (cfg_pready),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .fail_count         (fail_count),
    .results_pending    (results_pending),
    .results_checked    (results_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (holds_served < hold_requests && hold_left == 0) begin
      hold_left = 3000;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [ID_W-1:0] id, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_item_id <= id;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (last) seqs_sent++;
  endtask

  task automatic send_ids(input int ids[$]);
    foreach (ids[k]) send_word(ID_W'(ids[k]), k == ids.size() - 1);
  endtask

  // Drop valid and wait until every tally has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slots(input logic [SLOTS_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(REG_SLOTS_IN_USE));
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings_used++;
  endtask

  // One phase: set the slot count and idling, then random sequences
  task automatic run_phase(input logic [SLOTS_W-1:0] slots, input int tx_idle,
                           input int rx_stall, input int word_budget, input int first_len);
    int   target;
    int   len;
    int   pick;
    int   pool_base;
    int   pool_size;
    logic full_range;
    logic [ID_W-1:0] id;
    write_slots(slots);
    sender_idle_pct = tx_idle;
    rx_stall_pct    = rx_stall;
    target = words_sent + word_budget;
    len    = first_len;
    while (words_sent < target) begin
      // mostly short sequences; now and then a full or overlong one
      if (len == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       len = $urandom_range(SEQ_MAX_DEF + 1, SEQ_MAX_DEF + 12);
        else if (pick < 10) len = $urandom_range(SEQ_MAX_DEF - 28, SEQ_MAX_DEF);
        else                len = $urandom_range(1, 24);
      end
      if (len > SEQ_MAX_DEF) overflow_seqs++;
      // a narrow id pool gives hits and contested slots
      pool_base  = $urandom_range(0, ID_COUNT - 1);
      pool_size  = $urandom_range(1, 24);
      full_range = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        if (full_range) id = ID_W'($urandom_range(0, ID_COUNT - 1));
        else            id = ID_W'(pool_base + $urandom_range(0, pool_size - 1));
        send_word(id, k == len - 1);
      end
      len = 0;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int dir[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sequences with two slots
    write_slots(SLOTS_W'(2));
    dir = {127};
    send_ids(dir);
    dir = {0, 127, 0, 127, 5};
    send_ids(dir);
    dir = {1, 2, 3, 1, 2, 3};
    send_ids(dir);
    dir = {9, 9, 9};
    send_ids(dir);
    dir = {10, 20, 30, 40, 10};
    send_ids(dir);
    dir = {0, 0};
    send_ids(dir);
    wait_drained();

    // random phases across slot settings and idling patterns
    run_phase(SLOTS_W'(1), 0, 0, 130, 3);
    run_phase(SLOTS_W'(16), 85, 0, 130, SEQ_MAX_DEF);
    run_phase(SLOTS_W'(0), 0, 85, 130, SEQ_MAX_DEF + 7);
    run_phase(SLOTS_W'(31), 22, 22, 130, 20);
    // hold the result side so the block backs up onto its input
    hold_requests++;
    run_phase(SLOTS_W'(4), 0, 0, 130, 8);
    run_phase(SLOTS_W'($urandom_range(0, 31)), 85, 0, 130, SEQ_MAX_DEF + 12);
    run_phase(SLOTS_W'(3), 0, 85, 130, 0);
    run_phase(SLOTS_W'(8), 22, 22, 130, 0);
    run_phase(SLOTS_W'($urandom_range(0, 31)), 0, 0, 130, 0);

    repeat (300) @(posedge clk);
    $display("Sent %0d words in %0d sequences (%0d overlong) over %0d slot settings.",
             words_sent, seqs_sent, overflow_seqs, settings_used);
    $display("Checked %0d eviction counts with %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
